FILE: rtl/decimal_digit_layout_assert.svh
// Assertion macros used by the checker of the digit layout block.
`ifndef DECIMAL_DIGIT_LAYOUT_ASSERT_SVH
`define DECIMAL_DIGIT_LAYOUT_ASSERT_SVH

// Checked while out of reset.
`define DDL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define DDL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/ddl_pkg.sv
package ddl_pkg;

  localparam int MaxDigitsDefault = 16;
  localparam int Radix            = 10;
  localparam int QueueDepth       = 2;

  localparam int ValueW  = 32;
  localparam int CoordW  = 13;
  localparam int GlyphXW = 14;
  localparam int WidthW  = 8;
  localparam int MinW    = 5;
  localparam int KindW   = 2;
  localparam int DigitW  = 4;

  localparam logic [WidthW-1:0] DigitWidthReset = 8'd16;

  // floor(n / 10) == (n * RecipTen) >> RecipShift for every 32-bit n
  localparam logic [2*ValueW-1:0] RecipTen   = 64'h0000_0000_CCCC_CCCD;
  localparam int                  RecipShift = 35;

  typedef enum logic [KindW-1:0] {
    KindCenter = 2'd0,
    KindLeft   = 2'd1,
    KindRight  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [GlyphXW-1:0] x;
    logic [CoordW-1:0]  y;
    logic [WidthW-1:0]  w;
  } pos_t;

endpackage

FILE: rtl/ddl_front.sv
module ddl_front #(
  parameter int MAX_DIGITS = ddl_pkg::MaxDigitsDefault,
  localparam int CntW = $clog2(MAX_DIGITS + 1),
  localparam int DigsW = ddl_pkg::DigitW * MAX_DIGITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [ddl_pkg::ValueW-1:0] value_i,
  input  logic signed [ddl_pkg::CoordW-1:0] anchor_x_i,
  input  logic signed [ddl_pkg::CoordW-1:0] anchor_y_i,
  input  logic        [ddl_pkg::MinW-1:0]   min_digits_i,
  input  logic        [ddl_pkg::KindW-1:0]  kind_i,
  input  logic        [ddl_pkg::WidthW-1:0] width_i,
  output logic                              push_o,
  input  logic                              full_i,
  output logic        [DigsW-1:0]           digs_o,
  output logic        [CntW-1:0]            count_o,
  output ddl_pkg::pos_t                     pos_o
);

  localparam int TotW = CntW + ddl_pkg::WidthW;

  typedef enum logic [1:0] {
    FeIdle,
    FeDiv,
    FePush
  } state_e;

  state_e                         state_q, state_d;
  logic [ddl_pkg::ValueW-1:0]     mag_q, mag_d;
  logic [CntW-1:0]                n_q, n_d;
  logic [CntW-1:0]                mind_q, mind_d;
  logic [CntW-1:0]                count_q, count_d;
  ddl_pkg::kind_e                 kind_q, kind_d;
  logic [ddl_pkg::CoordW-1:0]     ax_q, ax_d;
  logic [ddl_pkg::CoordW-1:0]     y_q, y_d;
  logic [ddl_pkg::WidthW-1:0]     w_q, w_d;
  logic [DigsW-1:0]               digs_q, digs_d;

  logic [2*ddl_pkg::ValueW-1:0]   prod;
  logic [ddl_pkg::ValueW-1:0]     quot;
  logic [ddl_pkg::ValueW-1:0]     rem_full;
  logic [ddl_pkg::DigitW-1:0]     rem;
  logic [TotW-1:0]                total;
  logic [TotW-1:0]                base;
  logic [ddl_pkg::GlyphXW-1:0]    w_ext;
  logic                           kind_ok;

  assign prod     = {{ddl_pkg::ValueW{1'b0}}, mag_q} * ddl_pkg::RecipTen;
  assign quot     = ddl_pkg::ValueW'(prod >> ddl_pkg::RecipShift);
  assign rem_full = mag_q - ddl_pkg::ValueW'(quot * ddl_pkg::ValueW'(ddl_pkg::Radix));
  assign rem      = rem_full[ddl_pkg::DigitW-1:0];

  assign kind_ok = (kind_i == ddl_pkg::KindCenter) || (kind_i == ddl_pkg::KindLeft) ||
                   (kind_i == ddl_pkg::KindRight);

  assign total = TotW'(count_q) * TotW'(w_q);
  assign w_ext = ddl_pkg::GlyphXW'(w_q);

  always_comb begin
    case (kind_q)
      ddl_pkg::KindLeft:   base = total;
      ddl_pkg::KindCenter: base = total >> 1;
      ddl_pkg::KindRight:  base = '0;
      default:             base = '0;
    endcase
  end

  assign pos_o.x = ddl_pkg::GlyphXW'($signed(ax_q)) + ddl_pkg::GlyphXW'(base) +
                   (w_ext >> 1) - w_ext;
  assign pos_o.y = y_q;
  assign pos_o.w = w_q;

  assign busy_o  = (state_q != FeIdle);
  assign push_o  = (state_q == FePush) && (count_q != '0) && !full_i;
  assign digs_o  = digs_q;
  assign count_o = count_q;

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    n_d     = n_q;
    mind_d  = mind_q;
    count_d = count_q;
    kind_d  = kind_q;
    ax_d    = ax_q;
    y_d     = y_q;
    w_d     = w_q;
    digs_d  = digs_q;
    case (state_q)
      FeIdle: begin
        if (start_i && kind_ok) begin
          state_d = FeDiv;
          mag_d   = value_i[ddl_pkg::ValueW-1] ? (ddl_pkg::ValueW'(0) - value_i) : value_i;
          n_d     = '0;
          if (int'(min_digits_i) > MAX_DIGITS) begin
            mind_d = CntW'(MAX_DIGITS);
          end else begin
            mind_d = CntW'(min_digits_i);
          end
          kind_d  = ddl_pkg::kind_e'(kind_i);
          ax_d    = anchor_x_i;
          y_d     = anchor_y_i;
          w_d     = width_i;
          digs_d  = '0;
        end
      end
      FeDiv: begin
        if (mag_q == '0) begin
          state_d = FePush;
          count_d = (n_q > mind_q) ? n_q : mind_q;
        end else begin
          mag_d = quot;
          n_d   = n_q + CntW'(1);
          for (int e = 0; e < MAX_DIGITS; e++) begin
            if (n_q == CntW'(e)) begin
              digs_d[ddl_pkg::DigitW*e +: ddl_pkg::DigitW] = rem;
            end
          end
        end
      end
      FePush: begin
        if (count_q == '0 || !full_i) begin
          state_d = FeIdle;
        end
      end
      default: state_d = FeIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    n_q     <= n_d;
    mind_q  <= mind_d;
    count_q <= count_d;
    kind_q  <= kind_d;
    ax_q    <= ax_d;
    y_q     <= y_d;
    w_q     <= w_d;
    digs_q  <= digs_d;
  end

endmodule

FILE: rtl/ddl_queue.sv
module ddl_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int Depth = ddl_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  logic [DATA_W-1:0] mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/ddl_back.sv
module ddl_back #(
  parameter int MAX_DIGITS = ddl_pkg::MaxDigitsDefault,
  localparam int CntW = $clog2(MAX_DIGITS + 1),
  localparam int DigsW = ddl_pkg::DigitW * MAX_DIGITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               empty_i,
  output logic                               pop_o,
  input  logic        [DigsW-1:0]            digs_i,
  input  logic        [CntW-1:0]             count_i,
  input  ddl_pkg::pos_t                      pos_i,
  output logic                               valid_o,
  output logic signed [ddl_pkg::GlyphXW-1:0] glyph_x_o,
  output logic signed [ddl_pkg::CoordW-1:0]  glyph_y_o,
  output logic        [ddl_pkg::DigitW-1:0]  digit_o,
  output logic                               last_o
);

  logic                         active_q, active_d;
  logic [CntW-1:0]              rem_q, rem_d;
  logic [DigsW-1:0]             shr_q, shr_d;
  ddl_pkg::pos_t                pos_q, pos_d;
  logic                         valid_q, valid_d;
  logic [ddl_pkg::GlyphXW-1:0]  x_out_q, x_out_d;
  logic [ddl_pkg::CoordW-1:0]   y_out_q, y_out_d;
  logic [ddl_pkg::DigitW-1:0]   dig_out_q, dig_out_d;
  logic                         last_out_q, last_out_d;
  logic                         free;

  assign free  = !active_q || (rem_q == CntW'(1));
  assign pop_o = free && !empty_i;

  always_comb begin
    active_d   = active_q;
    rem_d      = rem_q;
    shr_d      = shr_q;
    pos_d      = pos_q;
    valid_d    = active_q;
    x_out_d    = x_out_q;
    y_out_d    = y_out_q;
    dig_out_d  = dig_out_q;
    last_out_d = last_out_q;
    if (active_q) begin
      x_out_d    = pos_q.x;
      y_out_d    = pos_q.y;
      dig_out_d  = shr_q[ddl_pkg::DigitW-1:0];
      last_out_d = (rem_q == CntW'(1));
      shr_d      = shr_q >> ddl_pkg::DigitW;
      pos_d.x    = pos_q.x - ddl_pkg::GlyphXW'(pos_q.w);
      rem_d      = rem_q - CntW'(1);
      if (rem_q == CntW'(1)) begin
        active_d = 1'b0;
      end
    end
    if (pop_o) begin
      active_d = 1'b1;
      rem_d    = count_i;
      shr_d    = digs_i;
      pos_d    = pos_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    shr_q      <= shr_d;
    pos_q      <= pos_d;
    x_out_q    <= x_out_d;
    y_out_q    <= y_out_d;
    dig_out_q  <= dig_out_d;
    last_out_q <= last_out_d;
  end

  assign valid_o   = valid_q;
  assign glyph_x_o = x_out_q;
  assign glyph_y_o = y_out_q;
  assign digit_o   = dig_out_q;
  assign last_o    = last_out_q;

endmodule

FILE: rtl/decimal_digit_layout.sv
// Decimal digit layout: turns one signed number into a run of glyph draws.
// Command channel: pulse start with the fields while busy is low; the item is
// taken at that edge. Alignment codes center, left and right are served; the
// unused code is dropped and emits nothing.
// Width register: cfg_valid_i with cfg_data_i writes the glyph width; ready is
// always high. Write it only while no item is in flight.
// Results: one draw per cycle on result_valid_o, least significant digit
// first, last_o on the most significant one. The receiver cannot stall; the
// digits of a run come out back to back.
// Flow: the front extracts the n significant digits (at most ten) one per
// cycle with a reciprocal multiply; busy stays high while it divides and
// then hands the job on, longer only while the two-entry job queue is full.
// A job passes from the front through the job queue to the back, whose
// outputs are registered. The front takes a new item once busy has fallen,
// while the back may still be emitting earlier runs at one draw per cycle.
// Reset clears the control state and the job queue and restores the width of
// 16; nothing is emitted until a new item arrives.
module decimal_digit_layout #(
  parameter int MAX_DIGITS = ddl_pkg::MaxDigitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic        [ddl_pkg::WidthW-1:0]  cfg_data_i,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ddl_pkg::ValueW-1:0]  value_i,
  input  logic signed [ddl_pkg::CoordW-1:0]  anchor_x_i,
  input  logic signed [ddl_pkg::CoordW-1:0]  anchor_y_i,
  input  logic        [ddl_pkg::MinW-1:0]    min_digits_i,
  input  logic        [ddl_pkg::KindW-1:0]   kind_i,
  output logic                               result_valid_o,
  output logic signed [ddl_pkg::GlyphXW-1:0] glyph_x_o,
  output logic signed [ddl_pkg::CoordW-1:0]  glyph_y_o,
  output logic        [ddl_pkg::DigitW-1:0]  digit_o,
  output logic                               last_o
);

  localparam int CntW  = $clog2(MAX_DIGITS + 1);
  localparam int DigsW = ddl_pkg::DigitW * MAX_DIGITS;
  localparam int JobW  = DigsW + CntW + $bits(ddl_pkg::pos_t);

  logic [ddl_pkg::WidthW-1:0] width_q;
  logic                       push;
  logic                       full;
  logic                       pop;
  logic                       empty;
  logic [DigsW-1:0]           fe_digs;
  logic [CntW-1:0]            fe_count;
  ddl_pkg::pos_t              fe_pos;
  logic [JobW-1:0]            q_data;
  logic [DigsW-1:0]           be_digs;
  logic [CntW-1:0]            be_count;
  ddl_pkg::pos_t              be_pos;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= ddl_pkg::DigitWidthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      width_q <= cfg_data_i;
    end
  end

  ddl_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .value_i     (value_i),
    .anchor_x_i  (anchor_x_i),
    .anchor_y_i  (anchor_y_i),
    .min_digits_i(min_digits_i),
    .kind_i      (kind_i),
    .width_i     (width_q),
    .push_o      (push),
    .full_i      (full),
    .digs_o      (fe_digs),
    .count_o     (fe_count),
    .pos_o       (fe_pos)
  );

  ddl_queue #(
    .DATA_W(JobW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({fe_digs, fe_count, fe_pos}),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (q_data)
  );

  assign {be_digs, be_count, be_pos} = q_data;

  ddl_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .pop_o    (pop),
    .digs_i   (be_digs),
    .count_i  (be_count),
    .pos_i    (be_pos),
    .valid_o  (result_valid_o),
    .glyph_x_o(glyph_x_o),
    .glyph_y_o(glyph_y_o),
    .digit_o  (digit_o),
    .last_o   (last_o)
  );

endmodule

FILE: rtl/ddl_checker.sv
`include "decimal_digit_layout_assert.svh"

module ddl_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic        [ddl_pkg::KindW-1:0]  kind_i,
  input logic                              result_valid_o,
  input logic signed [ddl_pkg::CoordW-1:0] glyph_y_o,
  input logic        [ddl_pkg::DigitW-1:0] digit_o,
  input logic                              last_o
);

  `DDL_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !result_valid_o && !busy, "activity in reset")
  `DDL_ASSERT(a_digit_range, result_valid_o |-> digit_o < ddl_pkg::DigitW'(ddl_pkg::Radix), "digit out of range")
  `DDL_ASSERT(a_run_unbroken, result_valid_o && !last_o |=> result_valid_o, "gap inside a digit run")
  `DDL_ASSERT(a_run_row, result_valid_o && !last_o |=> $stable(glyph_y_o), "row changed inside a run")
  `DDL_ASSERT(a_drop_unused, start && !busy && kind_i != ddl_pkg::KindCenter && kind_i != ddl_pkg::KindLeft && kind_i != ddl_pkg::KindRight |=> !busy, "unused alignment not dropped")

endmodule

bind decimal_digit_layout ddl_checker u_ddl_checker (.*);
